>>> hw/rtl/mbtba_pkg.sv
`default_nettype none
package mbtba_pkg;
  localparam int unsigned BinsDefault = 4096;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned BinW = 12;
  localparam int unsigned DataW = 32;
  localparam int unsigned AccW = 64;

  localparam logic [1:0] KIND_TRAIN  = 2'd0;
  localparam logic [1:0] KIND_BUILD  = 2'd1;
  localparam logic [1:0] KIND_APPLY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_READ  = 8'b00000100,
    ST_MUL   = 8'b00001000,
    ST_SUM   = 8'b00010000,
    ST_DIV   = 8'b00100000,
    ST_WRITE = 8'b01000000,
    ST_DONE  = 8'b10000000
  } state_t;

  // clip a 66-bit signed value to 64 bits
  function automatic logic [63:0] sat64(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = {3'b000, {63{1'b1}}};
      mn = {3'b111, {63{1'b0}}};
      if (v > mx) sat64 = mx[63:0];
      else if (v < mn) sat64 = mn[63:0];
      else sat64 = v[63:0];
    end
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/mbtba_ram.sv
`default_nettype none
module mbtba_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/mosse_bin_train_build_apply.sv
// channel | ports                                         | handshake
// input   | in_kind in_bin in_img_re/im in_target_re/im   | start high, busy low
// result  | out_bin out_re out_im out_zero_den out_saturated | out_valid, one cycle
//
// train holds busy after the accepting edge through read, multiply, scale/sum and
// write back. apply also passes a done state that loads the result, strobe in the next.
// build holds busy through read, divide, write back and done; the divider is a
// one-bit-per-cycle restoring divider run once for each filter part; on a zero
// denominator it does not run. after reset a clearing pass writes zero to every
// bin with busy high. one item at a time; results cannot be stalled.
`default_nettype none
module mosse_bin_train_build_apply
  import mbtba_pkg::*;
#(
  parameter int unsigned BINS = BinsDefault,
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_kind,
  input  wire logic [BinW-1:0]         in_bin,
  input  wire logic signed [DataW-1:0] in_img_re,
  input  wire logic signed [DataW-1:0] in_img_im,
  input  wire logic signed [DataW-1:0] in_target_re,
  input  wire logic signed [DataW-1:0] in_target_im,
  output logic                         out_valid,
  output logic [BinW-1:0]              out_bin,
  output logic signed [DataW-1:0]      out_re,
  output logic signed [DataW-1:0]      out_im,
  output logic                         out_zero_den,
  output logic                         out_saturated
);
  localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned DivSteps = AccW + FRAC_BITS;
  localparam int unsigned CntW = $clog2(DivSteps + 1);
  localparam int unsigned ClrW = $clog2(BINS + 1);

  state_t state_r, state_nxt;

  // item registers
  logic [1:0]                kind_r;
  logic [BinW-1:0]           bin_r;
  logic signed [DataW-1:0]   fr_r, fi_r, gr_r, gi_r;
  logic [ClrW-1:0]           clr_r;

  // memories: numerator re/im, denominator, filter {re,im}
  logic [AccW-1:0] nre_q, nim_q, den_q;
  logic [2*DataW-1:0] filt_q;
  logic            wr_acc, wr_filt;
  logic [AW-1:0]   waddr;
  logic [AccW-1:0] nre_w, nim_w, den_w;
  logic [2*DataW-1:0] filt_w;
  logic [AW-1:0]   raddr;

  logic clearing;
  assign clearing = (state_r == ST_CLEAR);
  assign waddr = clearing ? clr_r[AW-1:0] : AW'(bin_r);
  assign raddr = AW'(in_bin);

  mbtba_ram #(.Width(AccW), .Depth(BINS)) u_nre (
    .clk, .we(wr_acc), .waddr, .wdata(nre_w), .raddr, .rdata(nre_q));
  mbtba_ram #(.Width(AccW), .Depth(BINS)) u_nim (
    .clk, .we(wr_acc), .waddr, .wdata(nim_w), .raddr, .rdata(nim_q));
  mbtba_ram #(.Width(AccW), .Depth(BINS)) u_den (
    .clk, .we(wr_acc), .waddr, .wdata(den_w), .raddr, .rdata(den_q));
  mbtba_ram #(.Width(2*DataW), .Depth(BINS)) u_filt (
    .clk, .we(wr_filt), .waddr, .wdata(filt_w), .raddr, .rdata(filt_q));

  // latched memory words
  logic [AccW-1:0] a_nre_r, a_nim_r, a_den_r;
  logic signed [DataW-1:0] hr_r, hi_r;

  // products, registered: four 32x32 products
  logic signed [2*DataW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [DataW-1:0] m0_a, m0_b, m1_a, m1_b, m2_a, m2_b, m3_a, m3_b;

  always_comb begin
    if (kind_r == KIND_TRAIN) begin
      // gr*fr, gi*fi, gi*fr, gr*fi ; den uses fr*fr, fi*fi in extra pair
      m0_a = gr_r; m0_b = fr_r;
      m1_a = gi_r; m1_b = fi_r;
      m2_a = gi_r; m2_b = fr_r;
      m3_a = gr_r; m3_b = fi_r;
    end else begin
      m0_a = fr_r; m0_b = hr_r;
      m1_a = fi_r; m1_b = hi_r;
      m2_a = fr_r; m2_b = hi_r;
      m3_a = fi_r; m3_b = hr_r;
    end
  end

  logic signed [2*DataW-1:0] q0_r, q1_r;  // fr*fr, fi*fi

  // scaled sums
  logic signed [AccW+1:0] s0, s1, s2;
  always_comb begin
    if (kind_r == KIND_TRAIN) begin
      s0 = 66'(p0_r >>> FRAC_BITS) + 66'(p1_r >>> FRAC_BITS);
      s1 = 66'(p2_r >>> FRAC_BITS) - 66'(p3_r >>> FRAC_BITS);
    end else begin
      s0 = 66'(p0_r >>> FRAC_BITS) - 66'(p1_r >>> FRAC_BITS);
      s1 = 66'(p2_r >>> FRAC_BITS) + 66'(p3_r >>> FRAC_BITS);
    end
    s2 = 66'(q0_r >>> FRAC_BITS) + 66'(q1_r >>> FRAC_BITS);
  end

  // 32-bit clip of apply results and divider quotients
  function automatic logic [DataW:0] clip32(input logic signed [AccW+1:0] v);
    logic signed [AccW+1:0] mx, mn;
    begin
      mx = 66'(32'sh7fffffff);
      mn = -66'sd2147483648;
      if (v > mx) clip32 = {1'b1, mx[DataW-1:0]};
      else if (v < mn) clip32 = {1'b1, mn[DataW-1:0]};
      else clip32 = {1'b0, v[DataW-1:0]};
    end
  endfunction

  // clipped apply results, flag in the msb
  logic [DataW:0] c0, c1;
  assign c0 = clip32(s0);
  assign c1 = clip32(s1);

  // restoring divider, one quotient bit per cycle
  logic [AccW-1:0]  dmag_r;     // numerator magnitude, shifted out msb first
  logic [AccW:0]    rem_r;
  logic [AccW-1:0]  quo_r;
  logic             dneg_r;
  logic             part_r;     // 0 real, 1 imaginary
  logic [CntW-1:0]  cnt_r;
  logic [AccW:0]    rem_sh;
  logic [AccW-1:0]  quo_sh;
  logic             ge;
  localparam logic [AccW-1:0] QLim = 64'h2_0000_0000;

  always_comb begin
    rem_sh = {rem_r[AccW-1:0], dmag_r[AccW-1]};
    ge = (rem_sh >= {1'b0, a_den_r});
    quo_sh = {quo_r[AccW-2:0], ge};
    if (quo_sh > QLim) quo_sh = QLim;
    if (ge) rem_sh = rem_sh - {1'b0, a_den_r};
  end

  // signed quotient clipped to 32 bits
  logic [DataW:0] qclip;
  always_comb begin
    logic signed [AccW+1:0] sq;
    sq = dneg_r ? -66'(quo_sh) : 66'(quo_sh);
    qclip = clip32(sq);
  end

  logic signed [DataW-1:0] ore_r, oim_r;
  logic zd_r, sat_r;

  // write data
  assign nre_w = clearing ? '0 : sat64(66'($signed(a_nre_r)) + s0);
  assign nim_w = clearing ? '0 : sat64(66'($signed(a_nim_r)) + s1);
  assign den_w = clearing ? '0 : sat64(66'($signed(a_den_r)) + s2);
  assign filt_w = clearing ? '0 : {ore_r, oim_r};
  assign wr_acc = clearing || (state_r == ST_WRITE && kind_r == KIND_TRAIN);
  assign wr_filt = clearing || (state_r == ST_WRITE && kind_r == KIND_BUILD);

  assign busy = (state_r != ST_IDLE);

  logic accept;
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == ClrW'(BINS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        // out-of-range bins and the unused kind are dropped here
        if (accept && (32'(in_bin) < BINS) && in_kind != KIND_UNUSED)
          state_nxt = ST_READ;
      end
      ST_READ: state_nxt = (kind_r == KIND_BUILD) ? ST_DIV : ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_WRITE;
      ST_DIV: begin
        if ($signed(a_den_r) <= 0) state_nxt = ST_WRITE;
        else if (cnt_r == CntW'(DivSteps - 1) && part_r) state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = (kind_r == KIND_TRAIN) ? ST_IDLE : ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == ST_DONE);
      if (clearing) clr_r <= clr_r + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      bin_r <= in_bin;
      fr_r <= in_img_re;
      fi_r <= in_img_im;
      gr_r <= in_target_re;
      gi_r <= in_target_im;
    end
    if (state_r == ST_READ) begin
      a_nre_r <= nre_q;
      a_nim_r <= nim_q;
      a_den_r <= den_q;
      hr_r <= filt_q[2*DataW-1:DataW];
      hi_r <= filt_q[DataW-1:0];
      // divider starts on the real part
      dneg_r <= nre_q[AccW-1];
      dmag_r <= nre_q[AccW-1] ? (~nre_q + 1'b1) : nre_q;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
      part_r <= 1'b0;
      sat_r <= 1'b0;
      zd_r <= 1'b0;
      ore_r <= '0;
      oim_r <= '0;
    end
    if (state_r == ST_MUL) begin
      p0_r <= 64'(m0_a * m0_b);
      p1_r <= 64'(m1_a * m1_b);
      p2_r <= 64'(m2_a * m2_b);
      p3_r <= 64'(m3_a * m3_b);
      q0_r <= 64'(fr_r * fr_r);
      q1_r <= 64'(fi_r * fi_r);
    end
    if (state_r == ST_SUM && kind_r == KIND_APPLY) begin
      ore_r <= c0[DataW-1:0];
      oim_r <= c1[DataW-1:0];
      sat_r <= c0[DataW] | c1[DataW];
    end
    if (state_r == ST_DIV) begin
      if ($signed(a_den_r) <= 0) begin
        zd_r <= 1'b1;
      end else begin
        rem_r <= rem_sh;
        quo_r <= quo_sh;
        dmag_r <= {dmag_r[AccW-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(DivSteps - 1)) begin
          sat_r <= sat_r | qclip[DataW];
          cnt_r <= '0;
          rem_r <= '0;
          quo_r <= '0;
          if (!part_r) begin
            ore_r <= qclip[DataW-1:0];
            part_r <= 1'b1;
            dneg_r <= a_nim_r[AccW-1];
            dmag_r <= a_nim_r[AccW-1] ? (~a_nim_r + 1'b1) : a_nim_r;
          end else begin
            oim_r <= qclip[DataW-1:0];
          end
        end
      end
    end
    if (state_r == ST_DONE) begin
      out_bin <= bin_r;
      out_re <= ore_r;
      out_im <= oim_r;
      out_zero_den <= zd_r;
      out_saturated <= sat_r;
    end
  end
endmodule
`default_nettype wire

>>> test/tb_mosse_bin_train_build_apply.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_mosse_bin_train_build_apply;
  import mbtba_pkg::*;

  localparam int unsigned NBins = BinsDefault;
  localparam int unsigned Frac = FracBitsDefault;
  localparam int unsigned RandItems = 550;
  localparam int unsigned DrainCycles = 400;
  localparam longint unsigned CycleLimit = 3000000;
  localparam logic signed [DataW-1:0] QMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] QMin = 32'sh80000000;
  localparam logic signed [DataW-1:0] QOne = 32'sh00010000;

  // one transaction toward the block, with the chance of a gap before it
  typedef struct {
    logic [1:0]              kind;
    logic [BinW-1:0]         bin;
    logic signed [DataW-1:0] fr;
    logic signed [DataW-1:0] fi;
    logic signed [DataW-1:0] gr;
    logic signed [DataW-1:0] gi;
    int unsigned             gap_pct;
  } bin_item_t;

  // one filter bin or filtered bin coming back
  typedef struct {
    logic [BinW-1:0]         bin;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
    logic                    zd;
    logic                    sat;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = KIND_TRAIN;
  logic [BinW-1:0] in_bin = '0;
  logic signed [DataW-1:0] in_img_re = '0;
  logic signed [DataW-1:0] in_img_im = '0;
  logic signed [DataW-1:0] in_target_re = '0;
  logic signed [DataW-1:0] in_target_im = '0;
  logic out_valid;
  logic [BinW-1:0] out_bin;
  logic signed [DataW-1:0] out_re;
  logic signed [DataW-1:0] out_im;
  logic out_zero_den;
  logic out_saturated;

  // clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mosse_bin_train_build_apply u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_bin       (in_bin),
    .in_img_re    (in_img_re),
    .in_img_im    (in_img_im),
    .in_target_re (in_target_re),
    .in_target_im (in_target_im),
    .out_valid    (out_valid),
    .out_bin      (out_bin),
    .out_re       (out_re),
    .out_im       (out_im),
    .out_zero_den (out_zero_den),
    .out_saturated(out_saturated)
  );

  // mirror of the per-bin stores
  logic signed [AccW-1:0]  num_re_sum [NBins];
  logic signed [AccW-1:0]  num_im_sum [NBins];
  logic signed [AccW-1:0]  energy_sum [NBins];
  logic signed [DataW-1:0] filter_re  [NBins];
  logic signed [DataW-1:0] filter_im  [NBins];

  bin_item_t   pending_items[$];
  bin_result_t expected_bins[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_taken = 0;
  int unsigned trains_taken = 0;
  int unsigned builds_taken = 0;
  int unsigned applies_taken = 0;
  int unsigned rand_count = 0;
  longint unsigned cycles = 0;

  // fixed-point product, floor-scaled back by the fraction bits
  function automatic logic signed [AccW-1:0] qmul(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    logic signed [AccW-1:0] wa;
    logic signed [AccW-1:0] wb;
    logic signed [AccW-1:0] p;
    wa = a;
    wb = b;
    p = wa * wb;
    return p >>> Frac;
  endfunction

  // accumulator add with clipping at the 64-bit limits
  function automatic logic signed [AccW-1:0] acc_add(input logic signed [AccW-1:0] a,
                                                      input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = $signed({a[AccW-1], a}) + $signed({b[AccW-1], b});
    if (s[AccW] != s[AccW-1]) return s[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                             : {1'b0, {(AccW-1){1'b1}}};
    return s[AccW-1:0];
  endfunction

  // clip to the 32-bit output range, flagging any clip
  function automatic logic signed [DataW-1:0] clip_q(input logic signed [127:0] v,
                                                      inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return QMax;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return QMin;
    end
    return v[DataW-1:0];
  endfunction

  // num * 2^frac / den, truncated toward zero
  function automatic logic signed [DataW-1:0] filter_div(input logic signed [AccW-1:0] num,
                                                          input logic [AccW-1:0] den,
                                                          inout logic sat);
    logic signed [127:0] n;
    logic [127:0] mag;
    logic [127:0] q;
    n = num;
    mag = (n < 0) ? -n : n;
    q = (mag << Frac) / {64'd0, den};
    if (q > 128'h2_0000_0000) q = 128'h2_0000_0000;
    return clip_q((n < 0) ? -$signed(q) : $signed(q), sat);
  endfunction

  // apply one accepted transaction to the mirror; returns 1 when a result follows
  function automatic bit predict_bin(input bin_item_t it, output bin_result_t r);
    logic signed [AccW-1:0] den;
    logic sat;
    r = '{bin: it.bin, re: '0, im: '0, zd: 1'b0, sat: 1'b0};
    sat = 1'b0;
    case (it.kind)
      KIND_TRAIN: begin
        num_re_sum[it.bin] = acc_add(num_re_sum[it.bin],
                                     qmul(it.gr, it.fr) + qmul(it.gi, it.fi));
        num_im_sum[it.bin] = acc_add(num_im_sum[it.bin],
                                     qmul(it.gi, it.fr) - qmul(it.gr, it.fi));
        energy_sum[it.bin] = acc_add(energy_sum[it.bin],
                                     qmul(it.fr, it.fr) + qmul(it.fi, it.fi));
        return 1'b0;
      end
      KIND_BUILD: begin
        den = energy_sum[it.bin];
        if (den <= 0) begin
          r.zd = 1'b1;
        end else begin
          r.re = filter_div(num_re_sum[it.bin], den, sat);
          r.im = filter_div(num_im_sum[it.bin], den, sat);
        end
        filter_re[it.bin] = r.re;
        filter_im[it.bin] = r.im;
      end
      KIND_APPLY: begin
        r.re = clip_q(qmul(it.fr, filter_re[it.bin]) - qmul(it.fi, filter_im[it.bin]), sat);
        r.im = clip_q(qmul(it.fr, filter_im[it.bin]) + qmul(it.fi, filter_re[it.bin]), sat);
      end
      default: return 1'b0;  // unused kind is dropped
    endcase
    r.sat = sat;
    return 1'b1;
  endfunction

  task automatic add_item(input logic [1:0] kind, input logic [BinW-1:0] bin,
                          input logic signed [DataW-1:0] fr, input logic signed [DataW-1:0] fi,
                          input logic signed [DataW-1:0] gr, input logic signed [DataW-1:0] gi,
                          input int unsigned gap_pct);
    bin_item_t it;
    it = '{kind, bin, fr, fi, gr, gi, gap_pct};
    pending_items.insert(pending_items.size(), it);
  endtask

  // spectrum value: full range, small, extremes, zero or mid-size
  function automatic logic signed [DataW-1:0] rand_q();
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2: return $signed(32'($urandom_range(0, 1 << 19))) - (1 << 18);
      3: return QMax;
      4: return QMin;
      5: return '0;
      default: return $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
    endcase
  endfunction

  // driver: start stays high until the block takes the transaction
  always @(posedge clk) begin
    bin_item_t it;
    bin_result_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        it = '{in_kind, in_bin, in_img_re, in_img_im, in_target_re, in_target_im, 0};
        items_taken++;
        case (in_kind)
          KIND_TRAIN: trains_taken++;
          KIND_BUILD: builds_taken++;
          KIND_APPLY: applies_taken++;
          default: ;
        endcase
        if (predict_bin(it, r)) expected_bins.insert(expected_bins.size(), r);
      end
      if (!(start && busy)) begin
        if (pending_items.size() > 0 &&
            $urandom_range(0, 99) >= pending_items[0].gap_pct) begin
          it = pending_items.pop_front();
          start        <= 1'b1;
          in_kind      <= it.kind;
          in_bin       <= it.bin;
          in_img_re    <= it.fr;
          in_img_im    <= it.fi;
          in_target_re <= it.gr;
          in_target_im <= it.gi;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe must match the oldest expectation
  always @(posedge clk) begin
    bin_result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: bin %0d re %0d im %0d", out_bin, out_re, out_im);
      end else begin
        e = expected_bins.pop_front();
        if (out_bin !== e.bin || out_re !== e.re || out_im !== e.im ||
            out_zero_den !== e.zd || out_saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp bin %0d re %0d im %0d zd %0b sat %0b",
                      " / got bin %0d re %0d im %0d zd %0b sat %0b"},
                     e.bin, e.re, e.im, e.zd, e.sat,
                     out_bin, out_re, out_im, out_zero_den, out_saturated);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_mosse_bin_train_build_apply: errors");
      $finish;
    end
  end

  initial begin
    logic [1:0] k;
    logic [BinW-1:0] b;
    int unsigned pct;
    for (int i = 0; i < NBins; i++) begin
      num_re_sum[i] = '0;
      num_im_sum[i] = '0;
      energy_sum[i] = '0;
      filter_re[i]  = '0;
      filter_im[i]  = '0;
    end

    // directed: untrained bin gives zero denominator, zero filter gives zero output
    add_item(KIND_BUILD, BinW'(0), QMax, QMin, QMax, QMin, 12);
    add_item(KIND_APPLY, BinW'(0), QMax, QMax, '0, '0, 12);
    // plain bin: filter about 2 - j, then apply at both extremes to clip
    add_item(KIND_TRAIN, BinW'(1), QOne, '0, 2 * QOne, -QOne, 12);
    add_item(KIND_BUILD, BinW'(1), '0, '0, '0, '0, 12);
    add_item(KIND_APPLY, BinW'(1), QMax, QMax, '0, '0, 12);
    add_item(KIND_APPLY, BinW'(1), QMin, QMin, '0, '0, 12);
    // unused kind changes nothing, rebuilt filter must be the same
    add_item(KIND_UNUSED, BinW'(1), QMax, QMax, QMax, QMax, 12);
    add_item(KIND_BUILD, BinW'(1), '0, '0, '0, '0, 12);
    // last bin with full-scale values
    add_item(KIND_TRAIN, BinW'(NBins - 1), QMax, QMin, QMin, QMax, 12);
    add_item(KIND_BUILD, BinW'(NBins - 1), '0, '0, '0, '0, 12);
    add_item(KIND_APPLY, BinW'(NBins - 1), QMin, QMax, '0, '0, 12);
    // tiny energy, large numerator: quotient clips high
    add_item(KIND_TRAIN, BinW'(2), 256, '0, QMax, QMax, 12);
    add_item(KIND_BUILD, BinW'(2), '0, '0, '0, '0, 12);
    add_item(KIND_APPLY, BinW'(2), QOne, '0, '0, '0, 12);
    // same but negative numerator: quotient clips low
    add_item(KIND_TRAIN, BinW'(3), 256, 256, QMin, QMin, 12);
    add_item(KIND_BUILD, BinW'(3), '0, '0, '0, '0, 12);
    // energy below one lsb still counts as zero denominator
    add_item(KIND_TRAIN, BinW'(4), 1, 1, QMax, QMax, 12);
    add_item(KIND_BUILD, BinW'(4), '0, '0, '0, '0, 12);
    // short run of full-scale trains on one bin builds large accumulators
    for (int i = 0; i < 8; i++)
      add_item(KIND_TRAIN, BinW'(7), QMin, QMin, QMax, QMax, 12);
    add_item(KIND_BUILD, BinW'(7), '0, '0, '0, '0, 12);
    add_item(KIND_APPLY, BinW'(7), QMax, QMin, '0, '0, 12);
    add_item(KIND_UNUSED, BinW'(NBins - 1), '1, '1, '1, '1, 12);

    // random: mostly train..build..apply sequences on a few hot bins, some noise
    while (rand_count < RandItems) begin
      pct = (rand_count < RandItems / 3) ? 12 : (rand_count < 2 * RandItems / 3) ? 61 : 0;
      b = ($urandom_range(0, 9) < 7) ? BinW'($urandom_range(0, 7))
                                     : BinW'($urandom_range(0, NBins - 1));
      if ($urandom_range(0, 9) == 0) begin
        k = 2'($urandom_range(0, 3));
        add_item(k, BinW'($urandom), rand_q(), rand_q(), rand_q(), rand_q(), pct);
        if (k != KIND_UNUSED) rand_count++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_item(KIND_TRAIN, b, rand_q(), rand_q(), rand_q(), rand_q(), pct);
          rand_count++;
        end
        add_item(KIND_BUILD, b, rand_q(), rand_q(), rand_q(), rand_q(), pct);
        rand_count++;
        repeat ($urandom_range(1, 3)) begin
          add_item(KIND_APPLY, b, rand_q(), rand_q(), rand_q(), rand_q(), pct);
          rand_count++;
        end
      end
    end

    // hold reset, then release it; the block then clears its stores on its own
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_items.size() == 0 && !start && expected_bins.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d transactions (%0d train, %0d build, %0d apply), %0d results",
             items_taken, trains_taken, builds_taken, applies_taken, results_seen);
    $display("including zero-denominator builds, clipped quotients and clipped outputs");
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("tb_mosse_bin_train_build_apply: clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, expected_bins.size());
      $display("tb_mosse_bin_train_build_apply: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
